[hdl/assert_macros.svh]
// Assertion macros used by the BLAKE2b engine top level.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define B2B_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define B2B_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define B2B_ASSERT(lbl, prop, msg)
`define B2B_NEVER(lbl, expr, msg)
`endif
`endif

[hdl/b2b_pkg.sv]
// Types, constants and helper functions of the BLAKE2b engine.
// Depends on nothing; used by the core, the top level and the testbench.
package b2b_pkg;

  localparam int BLOCK_BYTES   = 128;
  localparam int IN_DEPTH_DEF  = 4;
  localparam int OUT_DEPTH_DEF = 8;

  localparam logic [63:0] PARAM_CONST = 64'h0000_0000_0101_0000;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  localparam logic CFG_DIGEST = 1'b0;
  localparam logic CFG_KEY    = 1'b1;

  typedef struct packed {
    logic        last_word;
    logic [3:0]  valid_bytes;
    logic [63:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic        digest_done;
    logic [2:0]  word_index;
    logic [63:0] digest_word;
  } out_item_t;

  typedef struct packed {
    logic       en;
    logic       idx;
    logic [6:0] data;
  } cfg_wr_t;

  localparam int IN_W  = $bits(in_item_t);
  localparam int OUT_W = $bits(out_item_t);

  function automatic logic [63:0] rotr64(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [6:0] clamp_digest(input logic [6:0] d);
    if (d == 7'd0) return 7'd1;
    if (d > 7'd64) return 7'd64;
    return d;
  endfunction

  // First chain word: IV xor the parameter block (fanout, depth, key and digest lengths).
  function automatic logic [63:0] chain0(input logic [6:0] d, input logic [6:0] k);
    logic [6:0] kc;
    kc = (k > 7'd64) ? 7'd64 : k;
    return IV[0] ^ PARAM_CONST ^ {49'b0, kc, 8'b0} ^ {57'b0, clamp_digest(d)};
  endfunction

  // Work vector index for a lane of a half round; role 0..3 is a, b, c, d.
  function automatic logic [3:0] lane_reg(input logic diag, input logic [1:0] lane,
                                          input logic [1:0] role);
    logic [1:0] off;
    off = diag ? role : 2'd0;
    return {role, 2'(lane + off)};
  endfunction

endpackage

[hdl/b2b_fifo.sv]
// Small first-in first-out queue of items, used on both sides of the engine.
// Depends on nothing but its parameters.
module b2b_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
  end
endmodule

[hdl/b2b_core.sv]
// Back end of the BLAKE2b engine: byte packing, padding, compression and digest output.
// Depends on b2b_pkg.
module b2b_core (
  input  logic               clk,
  input  logic               rst_n,
  input  b2b_pkg::cfg_wr_t   cfg,
  input  b2b_pkg::in_item_t  in_item,
  input  logic               in_empty,
  output logic               in_pop,
  output b2b_pkg::out_item_t out_item,
  output logic               out_push,
  input  logic               out_full
);
  import b2b_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ABSORB = 3'd1;
  localparam logic [2:0] ST_COMP   = 3'd2;
  localparam logic [2:0] ST_FOLD   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [6:0]  dig_r, dig_nxt, key_r, key_nxt;
  logic [6:0]  run_len_r, run_len_nxt;
  logic [63:0] h_r [8];
  logic [63:0] h_nxt [8];
  logic [63:0] cnt_lo_r, cnt_lo_nxt, cnt_hi_r, cnt_hi_nxt;
  logic [63:0] buf_r [16];
  logic [63:0] buf_nxt [16];
  logic [7:0]  fill_r, fill_nxt;
  logic [63:0] v_r [16];
  logic [63:0] v_nxt [16];
  logic [3:0]  rnd_r, rnd_nxt;
  logic        half_r, half_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic        final_r, final_nxt;
  logic [63:0] cur_word_r, cur_word_nxt;
  logic [3:0]  cur_nv_r, cur_nv_nxt;
  logic        cur_last_r, cur_last_nxt;
  logic [2:0]  emit_r, emit_nxt;

  logic [7:0]  room, take_n;
  logic [3:0]  rmod;
  logic [2:0]  last_idx;
  logic [63:0] emit_word;
  logic        idle_msg;

  assign room     = 8'(BLOCK_BYTES) - fill_r;
  assign take_n   = (room < {4'd0, cur_nv_r}) ? room : {4'd0, cur_nv_r};
  assign rmod     = (rnd_r >= 4'd10) ? 4'(rnd_r - 4'd10) : rnd_r;
  assign last_idx = 3'(7'(run_len_r - 7'd1) >> 3);
  assign idle_msg = (fill_r == 8'd0) && (cnt_lo_r == '0) && (cnt_hi_r == '0);

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      if (7'({emit_r, 3'b000}) + 7'(b) >= run_len_r) begin
        emit_word[8*b +: 8] = 8'h00;
      end else begin
        emit_word[8*b +: 8] = h_r[emit_r][8*b +: 8];
      end
    end
  end

  assign out_item.digest_word = emit_word;
  assign out_item.word_index  = emit_r;
  assign out_item.digest_done = (emit_r == last_idx);
  assign out_push             = (state_r == ST_EMIT) && !out_full;
  assign in_pop               = (state_r == ST_IDLE) && !in_empty;

  always_comb begin
    logic [64:0] lo_sum;
    logic [7:0]  add_n;
    logic        do_count, do_init, do_start, is_final;
    logic [7:0]  rel;
    logic [3:0]  ia, ib, ic, id, mi;
    logic [63:0] va, vb, vc, vd, an, cn;

    state_nxt    = state_r;
    dig_nxt      = dig_r;
    key_nxt      = key_r;
    run_len_nxt  = run_len_r;
    h_nxt        = h_r;
    cnt_lo_nxt   = cnt_lo_r;
    cnt_hi_nxt   = cnt_hi_r;
    buf_nxt      = buf_r;
    fill_nxt     = fill_r;
    v_nxt        = v_r;
    rnd_nxt      = rnd_r;
    half_nxt     = half_r;
    sub_nxt      = sub_r;
    final_nxt    = final_r;
    cur_word_nxt = cur_word_r;
    cur_nv_nxt   = cur_nv_r;
    cur_last_nxt = cur_last_r;
    emit_nxt     = emit_r;
    add_n        = 8'd0;
    do_count     = 1'b0;
    do_init      = 1'b0;
    do_start     = 1'b0;
    is_final     = 1'b0;
    lo_sum       = '0;
    rel          = 8'd0;
    ia           = 4'd0;
    ib           = 4'd0;
    ic           = 4'd0;
    id           = 4'd0;
    mi           = 4'd0;
    va           = '0;
    vb           = '0;
    vc           = '0;
    vd           = '0;
    an           = '0;
    cn           = '0;

    if (cfg.en) begin
      if (cfg.idx == CFG_DIGEST) begin
        dig_nxt = cfg.data;
      end else begin
        key_nxt = cfg.data;
      end
      if (idle_msg) begin
        do_start = 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!in_empty) begin
          cur_word_nxt = in_item.data_word;
          cur_nv_nxt   = (in_item.valid_bytes > 4'd8) ? 4'd8 : in_item.valid_bytes;
          cur_last_nxt = in_item.last_word;
          state_nxt    = ST_ABSORB;
        end
      end
      ST_ABSORB: begin
        if (cur_nv_r != 4'd0 && fill_r == 8'(BLOCK_BYTES)) begin
          // A held-back full block meets a new byte: compress it as non-final.
          add_n    = 8'(BLOCK_BYTES);
          do_count = 1'b1;
          do_init  = 1'b1;
          fill_nxt = 8'd0;
        end else if (cur_nv_r != 4'd0) begin
          for (int p = 0; p < BLOCK_BYTES; p++) begin
            rel = 8'(p) - fill_r;
            if (8'(p) >= fill_r && rel < take_n) begin
              buf_nxt[p/8][8*(p%8) +: 8] = cur_word_r[{rel[2:0], 3'b000} +: 8];
            end
          end
          fill_nxt     = 8'(fill_r + take_n);
          cur_nv_nxt   = 4'(cur_nv_r - take_n[3:0]);
          cur_word_nxt = cur_word_r >> {take_n[3:0], 3'b000};
          if (cur_nv_nxt == 4'd0 && !cur_last_r) begin
            state_nxt = ST_IDLE;
          end
        end else if (cur_last_r) begin
          for (int p = 0; p < BLOCK_BYTES; p++) begin
            if (8'(p) >= fill_r) begin
              buf_nxt[p/8][8*(p%8) +: 8] = 8'h00;
            end
          end
          add_n    = fill_r;
          do_count = 1'b1;
          do_init  = 1'b1;
          is_final = 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_COMP: begin
        for (int i = 0; i < 4; i++) begin
          ia = lane_reg(half_r, 2'(i), 2'd0);
          ib = lane_reg(half_r, 2'(i), 2'd1);
          ic = lane_reg(half_r, 2'(i), 2'd2);
          id = lane_reg(half_r, 2'(i), 2'd3);
          mi = SIGMA[rmod][{half_r, 2'(i), sub_r[1]}];
          va = v_r[ia];
          vb = v_r[ib];
          vc = v_r[ic];
          vd = v_r[id];
          an = va + vb + buf_r[mi];
          cn = vc + vd;
          if (!sub_r[0]) begin
            v_nxt[ia] = an;
            v_nxt[id] = sub_r[1] ? rotr64(vd ^ an, 16) : rotr64(vd ^ an, 32);
          end else begin
            v_nxt[ic] = cn;
            v_nxt[ib] = sub_r[1] ? rotr64(vb ^ cn, 63) : rotr64(vb ^ cn, 24);
          end
        end
        sub_nxt = 2'(sub_r + 2'd1);
        if (sub_r == 2'd3) begin
          half_nxt = !half_r;
          if (half_r) begin
            rnd_nxt = 4'(rnd_r + 4'd1);
            if (rnd_r == 4'd11) begin
              state_nxt = ST_FOLD;
            end
          end
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i] = h_r[i] ^ v_r[i] ^ v_r[i+8];
        end
        emit_nxt  = 3'd0;
        state_nxt = final_r ? ST_EMIT : ST_ABSORB;
      end
      ST_EMIT: begin
        if (!out_full) begin
          emit_nxt = 3'(emit_r + 3'd1);
          if (emit_r == last_idx) begin
            do_start  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_count) begin
      lo_sum     = {1'b0, cnt_lo_r} + {57'd0, add_n};
      cnt_lo_nxt = lo_sum[63:0];
      cnt_hi_nxt = cnt_hi_r + {63'd0, lo_sum[64]};
    end

    if (do_init) begin
      for (int i = 0; i < 8; i++) begin
        v_nxt[i] = h_r[i];
      end
      v_nxt[8]  = IV[0];
      v_nxt[9]  = IV[1];
      v_nxt[10] = IV[2];
      v_nxt[11] = IV[3];
      v_nxt[12] = IV[4] ^ cnt_lo_nxt;
      v_nxt[13] = IV[5] ^ cnt_hi_nxt;
      v_nxt[14] = is_final ? ~IV[6] : IV[6];
      v_nxt[15] = IV[7];
      rnd_nxt   = 4'd0;
      half_nxt  = 1'b0;
      sub_nxt   = 2'd0;
      final_nxt = is_final;
      state_nxt = ST_COMP;
    end

    if (do_start) begin
      h_nxt       = IV;
      h_nxt[0]    = chain0(dig_nxt, key_nxt);
      run_len_nxt = clamp_digest(dig_nxt);
      cnt_lo_nxt  = '0;
      cnt_hi_nxt  = '0;
      fill_nxt    = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    buf_r      <= buf_nxt;
    v_r        <= v_nxt;
    cur_word_r <= cur_word_nxt;
    cur_nv_r   <= cur_nv_nxt;
    cur_last_r <= cur_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      dig_r     <= 7'd64;
      key_r     <= 7'd0;
      run_len_r <= 7'd64;
      h_r       <= '{chain0(7'd64, 7'd0), IV[1], IV[2], IV[3], IV[4], IV[5], IV[6], IV[7]};
      cnt_lo_r  <= '0;
      cnt_hi_r  <= '0;
      fill_r    <= 8'd0;
      rnd_r     <= 4'd0;
      half_r    <= 1'b0;
      sub_r     <= 2'd0;
      final_r   <= 1'b0;
      emit_r    <= 3'd0;
    end else begin
      state_r   <= state_nxt;
      dig_r     <= dig_nxt;
      key_r     <= key_nxt;
      run_len_r <= run_len_nxt;
      h_r       <= h_nxt;
      cnt_lo_r  <= cnt_lo_nxt;
      cnt_hi_r  <= cnt_hi_nxt;
      fill_r    <= fill_nxt;
      rnd_r     <= rnd_nxt;
      half_r    <= half_nxt;
      sub_r     <= sub_nxt;
      final_r   <= final_nxt;
      emit_r    <= emit_nxt;
    end
  end
endmodule

[hdl/blake2b_hash_engine_top.sv]
// BLAKE2b hash engine (RFC 7693) with an input item queue and a digest item queue.
// A message goes in as little-endian 64-bit words; the digest leaves as up to eight
// words. The core is a single four-lane mixing unit: each cycle it performs one
// quarter of the G function on all four columns or diagonals at once. A 128-byte
// block is set up, mixed, and then folded into the chain value. Absorbing a word
// goes through a pop step and a pack step in the back end, so the pace of a long
// message is set by the mixing unit. The final block is compressed the same way,
// and the digest then leaves at one word per cycle while the result queue has
// room. Because a queue sits on each side, words can be pushed while a block is
// being compressed and finished digest words can wait to be popped without
// stopping the core. The configuration port is always ready; digest length and
// key length take effect at once when no byte of the current message has been
// absorbed, otherwise from the next message. A keyed message is expected with its
// key block, padded to 128 bytes, streamed ahead of the data. There is no clearing
// pass after reset.
`include "assert_macros.svh"
module blake2b_hash_engine_top #(
  parameter int IN_DEPTH  = b2b_pkg::IN_DEPTH_DEF,
  parameter int OUT_DEPTH = b2b_pkg::OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_digest_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import b2b_pkg::*;

  in_item_t  in_w, in_q;
  out_item_t out_w, out_q;
  cfg_wr_t   cfg_w;
  logic      q_empty, q_pop, r_push, r_full;

  // The configuration port never stalls.
  assign cfg_ready  = 1'b1;
  assign cfg_w.en   = cfg_valid;
  assign cfg_w.idx  = cfg_index;
  assign cfg_w.data = cfg_data;

  assign in_w.data_word   = in_data_word;
  assign in_w.valid_bytes = in_valid_bytes;
  assign in_w.last_word   = in_last_word;

  b2b_fifo #(.WIDTH(IN_W), .DEPTH(IN_DEPTH)) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (in_w),
    .full  (full),
    .pop   (q_pop),
    .dout  (in_q),
    .empty (q_empty)
  );

  b2b_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_w),
    .in_item  (in_q),
    .in_empty (q_empty),
    .in_pop   (q_pop),
    .out_item (out_w),
    .out_push (r_push),
    .out_full (r_full)
  );

  b2b_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .din   (out_w),
    .full  (r_full),
    .pop   (pop),
    .dout  (out_q),
    .empty (empty)
  );

  assign out_digest_word = out_q.digest_word;
  assign out_word_index  = out_q.word_index;
  assign out_digest_done = out_q.digest_done;

  // Digest words of one run leave in order, and a new run starts at word zero.
  `B2B_ASSERT(a_idx_step, (pop && !empty && !out_digest_done) |=> (empty || out_word_index == 3'($past(out_word_index) + 3'd1)), "digest word index skipped")
  `B2B_ASSERT(a_idx_first, (pop && !empty && out_digest_done) |=> (empty || out_word_index == 3'd0), "new digest does not start at word zero")
  // The core never pushes into a full result queue or pops an empty input queue.
  `B2B_NEVER(a_no_overrun, (r_push && r_full) || (q_pop && q_empty), "queue overrun")
endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for blake2b_hash_engine_top: message words in, digest words out.
// Depends on b2b_pkg for IV, SIGMA, config index names and result item type.
import b2b_pkg::*;

// Tracks accepted message words, predicts the digest words they cause and
// checks every popped digest word against the oldest prediction.
class digest_scoreboard;
  bit [6:0]  digest_len_reg;
  bit [6:0]  key_len_reg;
  bit [63:0] chain[8];
  bit [63:0] count_lo, count_hi;
  bit [63:0] msg_block[16];
  bit [63:0] mix_v[16];
  int unsigned fill;
  int unsigned run_len;
  out_item_t expected_digest[$];
  int errors;
  int digests_seen;

  function new();
    digest_len_reg = 64;
    key_len_reg = 0;
    errors = 0;
    digests_seen = 0;
    foreach (msg_block[i]) msg_block[i] = '0;
    restart();
  endfunction

  function bit [63:0] ror(bit [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // Load the chain value from the parameter block and clear the byte count.
  function void restart();
    bit [63:0] d, k;
    d = digest_len_reg;
    k = key_len_reg;
    if (d == 0) d = 1;
    if (d > 64) d = 64;
    if (k > 64) k = 64;
    foreach (chain[i]) chain[i] = IV[i];
    chain[0] ^= 64'h0101_0000 ^ (k << 8) ^ d;
    run_len = 32'(d);
    count_lo = 0;
    count_hi = 0;
    fill = 0;
  endfunction

  function void g_mix(int a, int b, int c, int d, bit [63:0] x, bit [63:0] y);
    mix_v[a] = mix_v[a] + mix_v[b] + x;
    mix_v[d] = ror(mix_v[d] ^ mix_v[a], 32);
    mix_v[c] = mix_v[c] + mix_v[d];
    mix_v[b] = ror(mix_v[b] ^ mix_v[c], 24);
    mix_v[a] = mix_v[a] + mix_v[b] + y;
    mix_v[d] = ror(mix_v[d] ^ mix_v[a], 16);
    mix_v[c] = mix_v[c] + mix_v[d];
    mix_v[b] = ror(mix_v[b] ^ mix_v[c], 63);
  endfunction

  function void compress(bit last_block);
    int r;
    for (int i = 0; i < 8; i++) begin
      mix_v[i] = chain[i];
      mix_v[i + 8] = IV[i];
    end
    mix_v[12] ^= count_lo;
    mix_v[13] ^= count_hi;
    if (last_block) mix_v[14] = ~mix_v[14];
    for (r = 0; r < 12; r++) begin
      g_mix(0, 4, 8, 12, msg_block[SIGMA[r % 10][0]], msg_block[SIGMA[r % 10][1]]);
      g_mix(1, 5, 9, 13, msg_block[SIGMA[r % 10][2]], msg_block[SIGMA[r % 10][3]]);
      g_mix(2, 6, 10, 14, msg_block[SIGMA[r % 10][4]], msg_block[SIGMA[r % 10][5]]);
      g_mix(3, 7, 11, 15, msg_block[SIGMA[r % 10][6]], msg_block[SIGMA[r % 10][7]]);
      g_mix(0, 5, 10, 15, msg_block[SIGMA[r % 10][8]], msg_block[SIGMA[r % 10][9]]);
      g_mix(1, 6, 11, 12, msg_block[SIGMA[r % 10][10]], msg_block[SIGMA[r % 10][11]]);
      g_mix(2, 7, 8, 13, msg_block[SIGMA[r % 10][12]], msg_block[SIGMA[r % 10][13]]);
      g_mix(3, 4, 9, 14, msg_block[SIGMA[r % 10][14]], msg_block[SIGMA[r % 10][15]]);
    end
    for (int i = 0; i < 8; i++) chain[i] ^= mix_v[i] ^ mix_v[i + 8];
  endfunction

  function void add_bytes(bit [63:0] n);
    count_lo += n;
    if (count_lo < n) count_hi += 1;
  endfunction

  // A full block is only compressed once a further byte shows up.
  function void absorb_byte(bit [7:0] b);
    int w, sh;
    if (fill >= 128) begin
      add_bytes(128);
      compress(1'b0);
      fill = 0;
    end
    w = fill >> 3;
    sh = (fill & 7) * 8;
    msg_block[w] = (msg_block[w] & ~(64'hFF << sh)) | (64'(b) << sh);
    fill++;
  endfunction

  function void write_reg(bit idx, bit [6:0] val);
    if (idx == CFG_DIGEST) digest_len_reg = val;
    else key_len_reg = val;
    if (fill == 0 && count_lo == 0 && count_hi == 0) restart();
  endfunction

  function void note_word(bit [63:0] data, bit [3:0] nbytes, bit last);
    int n, nwords;
    out_item_t e;
    bit [63:0] v;
    n = (nbytes > 8) ? 8 : nbytes;
    for (int i = 0; i < n; i++) absorb_byte(8'(data >> (8 * i)));
    if (!last) return;
    add_bytes(64'(fill));
    for (int b = fill; b < 128; b++) msg_block[b >> 3] &= ~(64'hFF << ((b & 7) * 8));
    compress(1'b1);
    nwords = (run_len + 7) / 8;
    for (int i = 0; i < nwords; i++) begin
      v = chain[i];
      if (run_len - 8 * i < 8) v &= (64'h1 << (8 * (run_len - 8 * i))) - 1;
      e.digest_word = v;
      e.word_index = 3'(i);
      e.digest_done = (i + 1 == nwords);
      expected_digest.push_back(e);
    end
    restart();
  endfunction

  function void check_digest(bit [63:0] word, bit [2:0] idx, bit done);
    out_item_t e;
    if (expected_digest.size() == 0) begin
      $error("digest word popped with none expected: %h", word);
      errors++;
      return;
    end
    e = expected_digest.pop_front();
    digests_seen++;
    if (word !== e.digest_word) begin
      $error("digest_word: expected %h, got %h", e.digest_word, word);
      errors++;
    end
    if (idx !== e.word_index) begin
      $error("word_index: expected %0d, got %0d", e.word_index, idx);
      errors++;
    end
    if (done !== e.digest_done) begin
      $error("digest_done: expected %0d, got %0d", e.digest_done, done);
      errors++;
    end
  endfunction

  function int pending();
    return expected_digest.size();
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 600000;
  localparam int N_ITEMS = 360;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] in_data_word = '0;
  logic [3:0]  in_valid_bytes = '0;
  logic        in_last_word = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_digest_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data = '0;

  digest_scoreboard sb = new();
  int cycles = 0;
  int words_sent = 0;
  int msgs_sent = 0;
  int keyed_msgs = 0;
  bit no_idle = 1'b0;

  blake2b_hash_engine_top uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly no gap, now and then a short one, rarely a long one.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Digest side: pop is changed at the falling edge and sampled at the rising edge.
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      stall = rand_gap();
      if (stall > 0) begin
        pop = 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop = 1'b1;
      @(posedge clk);
      if (rst_n && !empty) sb.check_digest(out_digest_word, out_word_index, out_digest_done);
    end
  end

  // Drive one word and hold it until the input queue takes it.
  task automatic push_word(input logic [63:0] data, input logic [3:0] nbytes,
                           input logic last);
    int gap;
    gap = rand_gap();
    repeat (gap) @(negedge clk);
    push = 1'b1;
    in_data_word = data;
    in_valid_bytes = nbytes;
    in_last_word = last;
    do @(posedge clk); while (full);
    sb.note_word(data, nbytes, last);
    words_sent++;
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [6:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Registers change only with the engine idle; words that yield no digest may
  // still be in flight, so also wait after draining for such a block to finish.
  task automatic set_regs(input logic [6:0] dlen, input logic [6:0] klen);
    wait_drained();
    repeat (200) @(negedge clk);
    write_cfg(CFG_DIGEST, dlen);
    write_cfg(CFG_KEY, klen);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Stream the key block: the key bytes zero-padded to nwords full words, 16 for a whole block.
  task automatic send_key_block(input int klen, input int nwords);
    logic [63:0] w;
    for (int i = 0; i < nwords; i++) begin
      w = rand64();
      for (int b = 0; b < 8; b++) if (i * 8 + b >= klen) w[b * 8 +: 8] = 8'h00;
      push_word(w, 4'd8, 1'b0);
    end
  endtask

  // One message of full words plus a last word, with occasional odd words inside if noisy is set.
  task automatic send_message(input int nfull, input logic [3:0] last_bytes, input bit noisy);
    int r;
    for (int i = 0; i < nfull; i++) begin
      r = $urandom_range(0, 99);
      if (noisy && r < 4) push_word(rand64(), 4'd0, 1'b0);
      else if (noisy && r < 8) push_word(rand64(), 4'($urandom_range(1, 7)), 1'b0);
      else if (noisy && r < 11) push_word(rand64(), 4'($urandom_range(9, 15)), 1'b0);
      else push_word(rand64(), 4'd8, 1'b0);
    end
    push_word(rand64(), last_bytes, 1'b1);
    msgs_sent++;
  endtask

  initial begin
    logic [6:0] dlen, klen;
    int klim, nfull;
    bit keyed;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: reset settings first, the empty string, extreme words,
    // odd byte counts and a held-back full block ended by an empty last word.
    push_word(64'h0, 4'd0, 1'b1);
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    push_word(64'h0, 4'd8, 1'b1);
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
    push_word(64'h0123_4567_89AB_CDEF, 4'd0, 1'b0);
    push_word(64'hA5A5_A5A5_A5A5_A5A5, 4'd3, 1'b0);
    push_word(64'h5A5A_5A5A_5A5A_5A5A, 4'd5, 1'b1);
    msgs_sent += 5;
    set_regs(7'd0, 7'd127);
    send_key_block(64, 16);
    keyed_msgs++;
    push_word(64'h0, 4'd0, 1'b1);
    msgs_sent++;
    set_regs(7'd127, 7'd0);
    send_message(16, 4'd0, 1'b0);
    set_regs(7'd1, 7'd1);
    send_key_block(1, 16);
    keyed_msgs++;
    send_message(0, 4'd1, 1'b0);
    set_regs(7'd64, 7'd0);

    // Random part: mostly well-formed messages, some noise and some broken key blocks.
    while (words_sent < N_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: dlen = 7'd64;
          1: dlen = 7'd1;
          2: dlen = 7'($urandom_range(65, 127));
          3: dlen = 7'd0;
          default: dlen = 7'($urandom_range(2, 63));
        endcase
        klim = $urandom_range(0, 5);
        klen = (klim < 2) ? 7'd0 : (klim == 2) ? 7'd64 : 7'($urandom_range(1, 127));
        set_regs(dlen, klen);
      end
      no_idle = ($urandom_range(0, 4) == 0);
      keyed = (sb.key_len_reg != 0);
      if (keyed) begin
        keyed_msgs++;
        klim = (sb.key_len_reg > 64) ? 64 : sb.key_len_reg;
        send_key_block(klim, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : 16);
      end
      case ($urandom_range(0, 9))
        0: nfull = 16 * $urandom_range(1, 2) - 1;
        1: nfull = 16 * $urandom_range(1, 2);
        default: nfull = $urandom_range(0, 12);
      endcase
      send_message(nfull, 4'($urandom_range(0, 9) == 0 ? $urandom_range(0, 15)
                                                       : $urandom_range(0, 8)),
                   $urandom_range(0, 2) == 0);
      // Let the engine run dry once with nothing new queued behind it.
      if (msgs_sent == 20) wait_drained();
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (300) @(negedge clk);
    $display("Covered %0d words in %0d messages (%0d keyed), %0d digest words checked.",
             words_sent, msgs_sent, keyed_msgs, sb.digests_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
